### sv/sphere_facet_subdivider_macros.svh
// Assertion macros for the facet subdivider RTL.
// No dependencies; included by the top level.
`ifndef SPHERE_FACET_SUBDIVIDER_MACROS_SVH
`define SPHERE_FACET_SUBDIVIDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/sfs_pkg.sv
// Types and constants of the sphere facet subdivider.
// No dependencies; used by every other file but the assertion macros.
package sfs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 18;
  localparam int MAG_W     = CW;
  localparam int SS_W      = 2 * MAG_W;
  localparam int LEN_W     = SS_W / 2;
  localparam int REM_W     = LEN_W + 2;
  localparam int SQ_PER    = 3;
  localparam int SQ_STAGES = LEN_W / SQ_PER;
  localparam int DQ_W      = FRAC_BITS + 2;
  localparam int DIV_PER   = 3;
  localparam int DIV_STAGES = (DQ_W + DIV_PER - 1) / DIV_PER;

  localparam logic signed [CW-1:0] CMAX = CW'(131071);

  typedef logic [CW-1:0]    coord_t;
  typedef coord_t [2:0]     vec_t;    // element 0 is x, 1 is y, 2 is z
  typedef vec_t [2:0]       facet_t;  // element 0 is A, 1 is B, 2 is C
  typedef logic [SS_W-1:0]  ss_t;
  typedef logic [LEN_W-1:0] len_t;

  // Child triangle codes in emission order.
  localparam logic [1:0] CHILD_A      = 2'd0;
  localparam logic [1:0] CHILD_B      = 2'd1;
  localparam logic [1:0] CHILD_C      = 2'd2;
  localparam logic [1:0] CHILD_CENTRE = 2'd3;

endpackage

### sv/sfs_in_if.sv
// Input channel of the facet subdivider: one triangle per word.
// Depends on sfs_pkg.
interface sfs_in_if;
  import sfs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz;

  modport source(output valid, in_ax, in_ay, in_az, in_bx, in_by, in_bz,
                 in_cx, in_cy, in_cz, input ready);
  modport sink(input valid, in_ax, in_ay, in_az, in_bx, in_by, in_bz,
               in_cx, in_cy, in_cz, output ready);
endinterface

### sv/sfs_out_if.sv
// Output channel of the facet subdivider: one child triangle per word.
// Depends on sfs_pkg.
interface sfs_out_if;
  import sfs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_ax, out_ay, out_az, out_bx, out_by, out_bz, out_cx, out_cy, out_cz;
  logic   last_child;
  logic   degenerate;

  modport source(output valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                 out_cx, out_cy, out_cz, last_child, degenerate, input ready);
  modport sink(input valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
               out_cx, out_cy, out_cz, last_child, degenerate, output ready);
endinterface

### sv/sfs_front.sv
// Front stages: input register, edge midpoints, squares and sums of squares.
// Depends on sfs_pkg.
module sfs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  sfs_pkg::facet_t in_facet,
  output logic           out_valid,
  output sfs_pkg::facet_t out_facet,
  output sfs_pkg::facet_t out_mid,
  output sfs_pkg::ss_t   out_ss [3]
);
  import sfs_pkg::*;

  function automatic coord_t mid(coord_t p, coord_t q);
    logic [CW:0] s;
    s = {p[CW-1], p} + {q[CW-1], q};
    return s[CW:1];
  endfunction

  function automatic logic [MAG_W-1:0] mag(coord_t m);
    return m[CW-1] ? MAG_W'(-m) : MAG_W'(m);
  endfunction

  logic   v1, v2, v3, v4;
  facet_t f1, f2, f3, f4;
  facet_t m2, m3, m4;
  ss_t    sq3 [3][3];
  ss_t    ss4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= in_facet;
      f2 <= f1;
      f3 <= f2;
      f4 <= f3;
      for (int i = 0; i < 3; i++) begin
        m2[0][i] <= mid(f1[0][i], f1[1][i]);
        m2[1][i] <= mid(f1[1][i], f1[2][i]);
        m2[2][i] <= mid(f1[2][i], f1[0][i]);
      end
      m3 <= m2;
      m4 <= m3;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          sq3[j][i] <= mag(m2[j][i]) * mag(m2[j][i]);
        end
        ss4[j] <= sq3[j][0] + sq3[j][1] + sq3[j][2];
      end
    end
  end

  assign out_valid = v4;
  assign out_facet = f4;
  assign out_mid   = m4;
  assign out_ss    = ss4;
endmodule

### sv/sfs_sqrt.sv
// Pipelined integer square root of the three sums of squares, a few bits a stage.
// Depends on sfs_pkg.
module sfs_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  sfs_pkg::facet_t in_facet,
  input  sfs_pkg::facet_t in_mid,
  input  sfs_pkg::ss_t    in_ss [3],
  output logic            out_valid,
  output sfs_pkg::facet_t out_facet,
  output sfs_pkg::facet_t out_mid,
  output sfs_pkg::len_t   out_len [3]
);
  import sfs_pkg::*;

  typedef struct packed {
    ss_t              n;
    logic [REM_W-1:0] rem;
    len_t             root;
  } sq_state_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sq_state_t sq_step(sq_state_t s);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    sq_state_t        o;
    r = {s.rem, s.n[SS_W-1 -: 2]};
    t = {2'b00, s.root, 2'b01};
    o.n = {s.n[SS_W-3:0], 2'b00};
    if (r >= t) begin
      o.rem  = REM_W'(r - t);
      o.root = {s.root[LEN_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(r);
      o.root = {s.root[LEN_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic      vld [SQ_STAGES];
  facet_t    fct [SQ_STAGES];
  facet_t    mds [SQ_STAGES];
  sq_state_t st  [SQ_STAGES][3];
  sq_state_t cur [SQ_STAGES][3];
  sq_state_t nxt [SQ_STAGES][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cur[0][j] = '{n: in_ss[j], rem: '0, root: '0};
      for (int k = 1; k < SQ_STAGES; k++) cur[k][j] = st[k-1][j];
      for (int k = 0; k < SQ_STAGES; k++) begin
        nxt[k][j] = cur[k][j];
        for (int t = 0; t < SQ_PER; t++) nxt[k][j] = sq_step(nxt[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < SQ_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fct[0] <= in_facet;
      mds[0] <= in_mid;
      for (int k = 1; k < SQ_STAGES; k++) begin
        fct[k] <= fct[k-1];
        mds[k] <= mds[k-1];
      end
      st <= nxt;
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign out_facet = fct[SQ_STAGES-1];
  assign out_mid   = mds[SQ_STAGES-1];
  always_comb begin
    for (int j = 0; j < 3; j++) out_len[j] = st[SQ_STAGES-1][j].root;
  end
endmodule

### sv/sfs_div.sv
// Pipelined restoring division that scales each midpoint onto the unit sphere.
// Depends on sfs_pkg.
module sfs_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  sfs_pkg::facet_t in_facet,
  input  sfs_pkg::facet_t in_mid,
  input  sfs_pkg::len_t   in_len [3],
  output logic            out_valid,
  output sfs_pkg::facet_t out_facet,
  output sfs_pkg::facet_t out_norm,
  output logic            out_degen
);
  import sfs_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [DQ_W-1:0]  num;
    logic [DQ_W-1:0]  q;
    logic             neg;
  } dv_state_t;

  function automatic dv_state_t dv_step(dv_state_t s, len_t d);
    logic [LEN_W:0] r;
    dv_state_t      o;
    r     = {s.rem, s.num[DQ_W-1]};
    o     = s;
    o.num = {s.num[DQ_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      o.rem = LEN_W'(r - {1'b0, d});
      o.q   = {s.q[DQ_W-2:0], 1'b1};
    end else begin
      o.rem = LEN_W'(r);
      o.q   = {s.q[DQ_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // The quotient stays below 2^(FRAC_BITS+2), so all magnitude bits but the low two
  // can seed the remainder directly.
  function automatic dv_state_t dv_init(coord_t m);
    logic [MAG_W-1:0] a;
    dv_state_t        o;
    a     = m[CW-1] ? MAG_W'(-m) : MAG_W'(m);
    o.rem = LEN_W'(a >> 2);
    o.num = {a[1:0], {FRAC_BITS{1'b0}}};
    o.q   = '0;
    o.neg = m[CW-1];
    return o;
  endfunction

  logic      vld [DIV_STAGES];
  facet_t    fct [DIV_STAGES];
  len_t      lns [DIV_STAGES][3];
  dv_state_t st  [DIV_STAGES][3][3];
  dv_state_t cur [DIV_STAGES][3][3];
  dv_state_t nxt [DIV_STAGES][3][3];
  len_t      dcur [DIV_STAGES][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dcur[0][j] = in_len[j];
      for (int k = 1; k < DIV_STAGES; k++) dcur[k][j] = lns[k-1][j];
      for (int i = 0; i < 3; i++) begin
        cur[0][j][i] = dv_init(in_mid[j][i]);
        for (int k = 1; k < DIV_STAGES; k++) cur[k][j][i] = st[k-1][j][i];
        for (int k = 0; k < DIV_STAGES; k++) begin
          nxt[k][j][i] = cur[k][j][i];
          for (int t = 0; t < DIV_PER; t++) begin
            if (k * DIV_PER + t < DQ_W) nxt[k][j][i] = dv_step(nxt[k][j][i], dcur[k][j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fct[0] <= in_facet;
      for (int k = 1; k < DIV_STAGES; k++) fct[k] <= fct[k-1];
      lns <= dcur;
      st  <= nxt;
    end
  end

  always_comb begin
    coord_t mg;
    out_degen = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (lns[DIV_STAGES-1][j] == '0) out_degen = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (st[DIV_STAGES-1][j][i].q > DQ_W'(CMAX)) mg = CMAX;
        else mg = CW'(st[DIV_STAGES-1][j][i].q);
        if (lns[DIV_STAGES-1][j] == '0) out_norm[j][i] = '0;
        else if (st[DIV_STAGES-1][j][i].neg) out_norm[j][i] = -mg;
        else out_norm[j][i] = mg;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_facet = fct[DIV_STAGES-1];
endmodule

### sv/sfs_emit.sv
// Output register that sends the four child triangles of one parent in turn.
// Depends on sfs_pkg and sfs_out_if.
module sfs_emit (
  input  logic            clk,
  input  logic            rst,
  output logic            en,
  input  logic            in_valid,
  input  sfs_pkg::facet_t in_facet,
  input  sfs_pkg::facet_t in_norm,
  input  logic            in_degen,
  sfs_out_if.source       dst
);
  import sfs_pkg::*;

  logic       busy;
  logic [1:0] cnt;
  facet_t     fct;
  facet_t     nrm;
  logic       degen;
  vec_t       v0, v1, v2;

  assign en = !busy || (dst.ready && cnt == CHILD_CENTRE);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= CHILD_A;
    end else if (en) begin
      busy <= in_valid;
      cnt  <= CHILD_A;
    end else if (dst.ready) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fct   <= in_facet;
      nrm   <= in_norm;
      degen <= in_degen;
    end
  end

  // Midpoint 0 lies on edge AB, 1 on BC and 2 on CA.
  always_comb begin
    case (cnt)
      CHILD_A: begin
        v0 = fct[0]; v1 = nrm[0]; v2 = nrm[2];
      end
      CHILD_B: begin
        v0 = nrm[0]; v1 = fct[1]; v2 = nrm[1];
      end
      CHILD_C: begin
        v0 = nrm[1]; v1 = fct[2]; v2 = nrm[2];
      end
      default: begin
        v0 = nrm[0]; v1 = nrm[1]; v2 = nrm[2];
      end
    endcase
  end

  assign dst.valid      = busy;
  assign dst.out_ax     = v0[0];
  assign dst.out_ay     = v0[1];
  assign dst.out_az     = v0[2];
  assign dst.out_bx     = v1[0];
  assign dst.out_by     = v1[1];
  assign dst.out_bz     = v1[2];
  assign dst.out_cx     = v2[0];
  assign dst.out_cy     = v2[1];
  assign dst.out_cz     = v2[2];
  assign dst.last_child = (cnt == CHILD_CENTRE);
  assign dst.degenerate = degen;
endmodule

### sv/sphere_facet_subdivider.sv
// One refinement step of a sphere mesh: each input word is a triangle, and four
// child word follow on the output, corner A, corner B, corner C, then the centre
// one, flagged by last_child. Edge midpoints are projected onto the unit sphere.
// A triangle passes four front stages, six square root stages and six divider
// stages, then holds the output register while its four children go out in turn;
// a new triangle enters as the last child is taken, or while that register is empty.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if, the sfs_* submodules and the macros header.
`include "sphere_facet_subdivider_macros.svh"

module sphere_facet_subdivider (
  input logic       clk,
  input logic       rst,
  sfs_in_if.sink    facet_in,
  sfs_out_if.source facet_out
);
  import sfs_pkg::*;

  logic   en;
  facet_t in_facet;
  logic   fr_valid, sq_valid, dv_valid, dv_degen;
  facet_t fr_facet, fr_mid, sq_facet, sq_mid, dv_facet, dv_norm;
  ss_t    fr_ss [3];
  len_t   sq_len [3];

  assign in_facet[0] = '{facet_in.in_az, facet_in.in_ay, facet_in.in_ax};
  assign in_facet[1] = '{facet_in.in_bz, facet_in.in_by, facet_in.in_bx};
  assign in_facet[2] = '{facet_in.in_cz, facet_in.in_cy, facet_in.in_cx};
  assign facet_in.ready = en;

  sfs_front u_front (
    .clk, .rst, .en,
    .in_valid (facet_in.valid), .in_facet (in_facet),
    .out_valid (fr_valid), .out_facet (fr_facet), .out_mid (fr_mid), .out_ss (fr_ss)
  );

  sfs_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (fr_valid), .in_facet (fr_facet), .in_mid (fr_mid), .in_ss (fr_ss),
    .out_valid (sq_valid), .out_facet (sq_facet), .out_mid (sq_mid), .out_len (sq_len)
  );

  sfs_div u_div (
    .clk, .rst, .en,
    .in_valid (sq_valid), .in_facet (sq_facet), .in_mid (sq_mid), .in_len (sq_len),
    .out_valid (dv_valid), .out_facet (dv_facet), .out_norm (dv_norm),
    .out_degen (dv_degen)
  );

  sfs_emit u_emit (
    .clk, .rst, .en,
    .in_valid (dv_valid), .in_facet (dv_facet), .in_norm (dv_norm),
    .in_degen (dv_degen), .dst (facet_out)
  );

  // A stalled output word freezes the whole pipeline.
  `SFS_ASSERT_NOW(a_stall_freezes, clk, rst, facet_out.valid && !facet_out.ready, !facet_in.ready)
  // The children of one parent come out back to back and share the flag.
  `SFS_ASSERT_NEXT(a_degen_same, clk, rst, facet_out.valid && facet_out.ready && !facet_out.last_child, facet_out.valid && facet_out.degenerate == $past(facet_out.degenerate))
  `SFS_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !facet_out.valid)
endmodule

### tb/tb_sphere_facet_subdivider.sv
// Self-checking testbench of the sphere facet subdivider: directed and random triangles,
// predicted children compared word by word. Depends on sfs_pkg, sfs_in_if, sfs_out_if
// and the sphere_facet_subdivider RTL.
module tb_sphere_facet_subdivider;
  import sfs_pkg::*;

  typedef struct packed {
    vec_t   v1, v2, v3;
    logic   last_child;
    logic   degenerate;
  } child_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   mismatches = 0;
  int   children_seen = 0;
  int   degenerate_seen = 0;
  int   triangles_sent = 0;
  bit   failed = 1'b0;
  child_t expected_children[$];

  sfs_in_if  facet_in();
  sfs_out_if facet_out();

  sphere_facet_subdivider dut (
    .clk(clk),
    .rst(rst),
    .facet_in(facet_in.sink),
    .facet_out(facet_out.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Projects the midpoint of p and q onto the unit sphere; sets zero_len if it has no length.
  function automatic vec_t project_midpoint(vec_t p, vec_t q, ref bit zero_len);
    longint m[3];
    longint unsigned sq_sum, len, mag, quot, rem, bitv;
    longint sv;
    vec_t r;
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (longint'($signed(p[i])) + longint'($signed(q[i]))) >>> 1;
      mag = (m[i] < 0) ? -m[i] : m[i];
      sq_sum += mag * mag;
    end
    // Bitwise integer square root, floor.
    len = 0;
    rem = sq_sum;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem -= len + bitv;
        len = (len >> 1) + bitv;
      end else begin
        len >>= 1;
      end
      bitv >>= 2;
    end
    if (len == 0) begin
      zero_len = 1'b1;
      return '0;
    end
    for (int i = 0; i < 3; i++) begin
      mag = (m[i] < 0) ? -m[i] : m[i];
      quot = (mag << FRAC_BITS) / len;
      sv = (m[i] < 0) ? -longint'(quot) : longint'(quot);
      if (sv > 131071) sv = 131071;
      if (sv < -131072) sv = -131072;
      r[i] = coord_t'(sv);
    end
    return r;
  endfunction

  function automatic void predict_children(facet_t f);
    bit zero_len;
    vec_t pa, pb, pc;
    zero_len = 1'b0;
    pa = project_midpoint(f[0], f[1], zero_len);
    pb = project_midpoint(f[1], f[2], zero_len);
    pc = project_midpoint(f[2], f[0], zero_len);
    expected_children.push_back('{f[0], pa, pc, 1'b0, zero_len});
    expected_children.push_back('{pa, f[1], pb, 1'b0, zero_len});
    expected_children.push_back('{pb, f[2], pc, 1'b0, zero_len});
    expected_children.push_back('{pa, pb, pc, 1'b1, zero_len});
  endfunction

  // Valid stays high straight into the next word when no gap is drawn.
  task automatic send_triangle(facet_t f);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      facet_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    facet_in.valid <= 1'b1;
    {facet_in.in_az, facet_in.in_ay, facet_in.in_ax} <= f[0];
    {facet_in.in_bz, facet_in.in_by, facet_in.in_bx} <= f[1];
    {facet_in.in_cz, facet_in.in_cy, facet_in.in_cx} <= f[2];
    do @(posedge clk); while (!facet_in.ready);
    predict_children(f);
    triangles_sent++;
  endtask

  // Receiver: random stalls, one draw per word.
  initial begin
    int stall;
    facet_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        facet_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      facet_out.ready <= 1'b1;
      do @(posedge clk); while (!facet_out.valid);
    end
  end

  always @(posedge clk) begin
    child_t got, want;
    if (!rst && facet_out.valid && facet_out.ready) begin
      got.v1 = {facet_out.out_az, facet_out.out_ay, facet_out.out_ax};
      got.v2 = {facet_out.out_bz, facet_out.out_by, facet_out.out_bx};
      got.v3 = {facet_out.out_cz, facet_out.out_cy, facet_out.out_cx};
      got.last_child = facet_out.last_child;
      got.degenerate = facet_out.degenerate;
      children_seen++;
      if (got.degenerate) degenerate_seen++;
      if (expected_children.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected child word %h", got);
      end else begin
        want = expected_children.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("Child mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  function automatic coord_t any_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(131071);
      1: return coord_t'(-131072);
      2: return coord_t'($urandom_range(0, 2) * 65536 - 65536);
      3: return coord_t'($urandom_range(0, 15) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    facet_t f;
    // Octahedron face, then its mirror.
    f = '{'{coord_t'(0), coord_t'(0), coord_t'(65536)},
          '{coord_t'(0), coord_t'(65536), coord_t'(0)},
          '{coord_t'(65536), coord_t'(0), coord_t'(0)}};
    send_triangle(f);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) f[i][j] = -f[i][j];
    send_triangle(f);
    // All corners at one extreme.
    send_triangle('{3{'{3{coord_t'(131071)}}}});
    send_triangle('{3{'{3{coord_t'(-131072)}}}});
    // Zero triangle and opposite corners cancelling to zero-length midpoints.
    send_triangle('0);
    f = '{'{3{coord_t'(65536)}}, '{3{coord_t'(-65536)}}, '{3{coord_t'(65536)}}};
    send_triangle(f);
    // Sum of -1 shifts to -1, of 1 shifts to 0.
    f = '{'{3{coord_t'(-1)}}, '{3{coord_t'(0)}}, '{3{coord_t'(1)}}};
    send_triangle(f);
    f = '{'{coord_t'(131071), coord_t'(-131072), coord_t'(1)},
          '{coord_t'(-131072), coord_t'(131071), coord_t'(-1)},
          '{coord_t'(0), coord_t'(131071), coord_t'(-131072)}};
    send_triangle(f);
  endtask

  task automatic test_random();
    facet_t f;
    for (int n = 0; n < 500; n++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) f[i][j] = any_coord();
      // Now and then make one edge cancel exactly.
      if ($urandom_range(0, 15) == 0)
        for (int j = 0; j < 3; j++) f[1][j] = -f[0][j];
      send_triangle(f);
    end
  endtask

  initial begin
    facet_in.valid = 1'b0;
    {facet_in.in_ax, facet_in.in_ay, facet_in.in_az} = '0;
    {facet_in.in_bx, facet_in.in_by, facet_in.in_bz} = '0;
    {facet_in.in_cx, facet_in.in_cy, facet_in.in_cz} = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    facet_in.valid <= 1'b0;
    while (expected_children.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d triangles, checked %0d child words (%0d degenerate), %0d mismatches",
             triangles_sent, children_seen, degenerate_seen, mismatches);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
